[design/dss_pkg.sv]
// shared types and constants of the delimiter stream splitter
`timescale 1ns / 1ps

package dss_pkg;

    localparam int MAX_DELIM_BYTES = 8;
    localparam int PEND_DEPTH      = MAX_DELIM_BYTES - 1;
    localparam int SLOTS           = MAX_DELIM_BYTES + 1;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int PAT_W           = 64;
    localparam int IDX_W           = $clog2(MAX_DELIM_BYTES);
    localparam int CNT_W           = $clog2(MAX_DELIM_BYTES);
    localparam int POS_W           = $clog2(MAX_DELIM_BYTES + 1);
    localparam int CFG_IDX_W       = 1;
    localparam int Q_DEPTH         = 2;
    localparam int QP_W            = $clog2(Q_DEPTH);
    localparam int QC_W            = $clog2(Q_DEPTH + 1);

    localparam logic [LEN_W-1:0]     LEN_RESET       = 4'd1;
    localparam logic [PAT_W-1:0]     PAT_RESET       = 64'd44;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PATTERN = 1'b1;

    // one scanned input byte: window bytes and the result slots it produces
    // slot p < MAX_DELIM_BYTES sits at window byte p, the top slot is a trailing end mark
    typedef struct packed {
        logic [MAX_DELIM_BYTES-1:0][BYTE_W-1:0] win;
        logic [SLOTS-1:0]                       emit;
        logic [SLOTS-1:0]                       data;
        logic [SLOTS-1:0]                       pend;
    } t_run;

endpackage

[design/dss_src_if.sv]
// source byte channel
`timescale 1ns / 1ps

interface dss_src_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       source_last;

    modport source (output valid, output source_byte, output source_last, input ready);
    modport sink   (input valid, input source_byte, input source_last, output ready);
endinterface

[design/dss_piece_if.sv]
// piece result channel
`timescale 1ns / 1ps

interface dss_piece_if;
    logic       valid;
    logic       ready;
    logic [7:0] piece_byte;
    logic       byte_valid;
    logic       piece_end;
    logic       run_last;

    modport source (output valid, output piece_byte, output byte_valid, output piece_end,
                    output run_last, input ready);
    modport sink   (input valid, input piece_byte, input byte_valid, input piece_end,
                    input run_last, output ready);
endinterface

[design/dss_front.sv]
// front end: config registers, held-back bytes and delimiter scan of each beat
`timescale 1ns / 1ps

module dss_front
    import dss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PAT_W-1:0]     i_cfg_data,
    dss_src_if.sink              i_src,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_run                 o_run
);

    logic [LEN_W-1:0]  r_len;
    logic [PAT_W-1:0]  r_pat;
    logic [BYTE_W-1:0] r_pend [PEND_DEPTH];
    logic [CNT_W-1:0]  r_cnt;
    logic              r_open;

    logic [BYTE_W-1:0] n_pend [PEND_DEPTH];
    logic [CNT_W-1:0]  n_cnt;
    logic              n_open;

    logic [POS_W-1:0]                        len;
    logic [POS_W-1:0]                        w;
    logic [POS_W-1:0]                        h;
    logic [POS_W-1:0]                        sidx;
    logic [MAX_DELIM_BYTES-1:0][BYTE_W-1:0]  win;
    logic [MAX_DELIM_BYTES-1:0][BYTE_W-1:0]  pat;
    logic [MAX_DELIM_BYTES-1:0]              full;
    logic [MAX_DELIM_BYTES-1:0]              pre;
    logic [MAX_DELIM_BYTES-1:0]              p_emit;
    logic [MAX_DELIM_BYTES-1:0]              p_data;
    logic [MAX_DELIM_BYTES-1:0]              p_pend;
    logic                                    bare;
    logic                                    stop;
    logic                                    found;
    logic [IDX_W-1:0]                        last_idx;
    logic                                    open_after;
    logic                                    accept;

    assign i_src.ready = !i_q_full;
    assign accept      = i_src.valid && !i_q_full;

    always_comb begin
        if (r_len == '0) begin
            len = POS_W'(1);
        end else if (r_len > LEN_W'(MAX_DELIM_BYTES)) begin
            len = POS_W'(MAX_DELIM_BYTES);
        end else begin
            len = POS_W'(r_len);
        end
        w = POS_W'(r_cnt) + POS_W'(1);

        for (int p = 0; p < PEND_DEPTH; p++) begin
            win[p] = (CNT_W'(p) < r_cnt) ? r_pend[p] : i_src.source_byte;
        end
        win[MAX_DELIM_BYTES-1] = i_src.source_byte;
        for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
            pat[i] = r_pat[i*BYTE_W +: BYTE_W];
        end

        // full match and prefix-of-tail match at every window position
        for (int p = 0; p < MAX_DELIM_BYTES; p++) begin
            full[p] = (POS_W'(p) + len <= w);
            pre[p]  = (POS_W'(p) < w) && (w < POS_W'(p) + len);
            for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
                if (p + i < MAX_DELIM_BYTES) begin
                    if (POS_W'(i) < len && win[p+i] != pat[i]) begin
                        full[p] = 1'b0;
                    end
                    if (POS_W'(p + i) < w && win[p+i] != pat[i]) begin
                        pre[p] = 1'b0;
                    end
                end
            end
        end

        // leftmost non-overlapping walk over the window
        h      = '0;
        stop   = 1'b0;
        p_emit = '0;
        p_data = '0;
        p_pend = '0;
        for (int s = 0; s < MAX_DELIM_BYTES; s++) begin
            if (!stop && h < w) begin
                if (full[h[IDX_W-1:0]]) begin
                    p_emit[h[IDX_W-1:0]] = 1'b1;
                    p_pend[h[IDX_W-1:0]] = 1'b1;
                    h = h + len;
                end else if (pre[h[IDX_W-1:0]]) begin
                    stop = 1'b1;
                end else begin
                    p_emit[h[IDX_W-1:0]] = 1'b1;
                    p_data[h[IDX_W-1:0]] = 1'b1;
                    h = h + POS_W'(1);
                end
            end
        end

        // last byte flushes whatever is still held
        if (i_src.source_last) begin
            for (int p = 0; p < MAX_DELIM_BYTES; p++) begin
                if (POS_W'(p) >= h && POS_W'(p) < w) begin
                    p_emit[p] = 1'b1;
                    p_data[p] = 1'b1;
                end
            end
        end

        found      = 1'b0;
        last_idx   = '0;
        open_after = r_open;
        for (int p = 0; p < MAX_DELIM_BYTES; p++) begin
            if (p_emit[p]) begin
                found      = 1'b1;
                last_idx   = IDX_W'(p);
                open_after = p_data[p];
            end
        end

        bare = 1'b0;
        if (i_src.source_last && open_after) begin
            if (found) begin
                p_pend[last_idx] = 1'b1;
            end else begin
                bare = 1'b1;
            end
        end

        n_cnt  = i_src.source_last ? '0 : CNT_W'(w - h);
        n_open = i_src.source_last ? 1'b0 : open_after;
        for (int i = 0; i < PEND_DEPTH; i++) begin
            sidx = h + POS_W'(i);
            if (sidx < POS_W'(MAX_DELIM_BYTES)) begin
                n_pend[i] = win[sidx[IDX_W-1:0]];
            end else begin
                n_pend[i] = win[0];
            end
        end
    end

    assign o_run.win  = win;
    assign o_run.emit = {bare, p_emit};
    assign o_run.data = {1'b0, p_data};
    assign o_run.pend = {bare, p_pend};
    assign o_push     = accept && (bare || (|p_emit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LEN_RESET;
            r_pat  <= PAT_RESET;
            r_cnt  <= '0;
            r_open <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IDX_LENGTH:  r_len <= i_cfg_data[LEN_W-1:0];
                    CFG_IDX_PATTERN: r_pat <= i_cfg_data;
                    default:         r_len <= r_len;
                endcase
            end
            if (accept) begin
                r_cnt  <= n_cnt;
                r_open <= n_open;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

endmodule

[design/dss_queue.sv]
// short run queue between the scan front end and the result sequencer
`timescale 1ns / 1ps

module dss_queue
    import dss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_run,
    output logic o_full,
    output logic o_head_valid,
    output t_run o_head,
    input  logic i_pop
);

    t_run             r_mem [Q_DEPTH];
    logic [QP_W-1:0]  r_wr;
    logic [QP_W-1:0]  r_rd;
    logic [QC_W-1:0]  r_count;

    assign o_full       = (r_count == QC_W'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr + QP_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd + QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

endmodule

[design/dss_back.sv]
// back end: walks the result slots of the queue head, one beat per cycle while the receiver is ready
`timescale 1ns / 1ps

module dss_back
    import dss_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_head_valid,
    input  t_run         i_head,
    output logic         o_pop,
    dss_piece_if.source  o_piece
);

    logic [SLOTS-1:0]  r_done;
    logic              r_ovalid;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_obv;
    logic              r_oend;
    logic              r_olast;

    logic [SLOTS-1:0]  rem;
    logic [SLOTS-1:0]  pick;
    logic              is_last;
    logic              load;
    logic [BYTE_W-1:0] sel_byte;

    always_comb begin
        rem     = i_head.emit & ~r_done;
        // lowest pending slot
        pick    = rem & (~rem + SLOTS'(1));
        is_last = ((rem & ~pick) == '0);
        sel_byte = '0;
        for (int p = 0; p < MAX_DELIM_BYTES; p++) begin
            if (pick[p] && i_head.data[p]) begin
                sel_byte = sel_byte | i_head.win[p];
            end
        end
    end

    assign load  = i_head_valid && (!r_ovalid || o_piece.ready);
    assign o_pop = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_done   <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_done   <= is_last ? '0 : (r_done | pick);
            end else if (o_piece.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_obyte <= sel_byte;
            r_obv   <= |(pick & i_head.data);
            r_oend  <= |(pick & i_head.pend);
            r_olast <= is_last;
        end
    end

    assign o_piece.valid      = r_ovalid;
    assign o_piece.piece_byte = r_obyte;
    assign o_piece.byte_valid = r_obv;
    assign o_piece.piece_end  = r_oend;
    assign o_piece.run_last   = r_olast;

endmodule

[design/delimiter_stream_splitter.sv]
// top level of the delimiter stream splitter
//
// i_src carries one source byte per beat, source_last on the final byte of
// a string. o_piece carries one result per beat: a piece byte (byte_valid
// high), or a bare end mark (byte_valid low, piece_byte zero) where a
// delimiter or the end of a string closes a piece. piece_end marks the end
// of a piece and run_last the last result caused by one source byte. The
// config port writes delim_length (index 0) and delim_pattern (index 1).
// The first result of a source beat passes the run queue and then the
// output register on its way to o_piece. Throughput: one source beat per
// cycle while the run queue is not full; a beat that causes k results holds
// the output sequencer until all k are out, and a two-entry run queue lets
// the scan keep taking beats meanwhile. A beat that causes no result (byte
// held as a possible delimiter start) costs the sequencer nothing.
// When the receiver stalls, the output register holds its beat, the queue
// fills and then i_src.ready drops. Reset clears held bytes, the open-piece
// flag and the queue, and sets length 1 with delimiter ','.
`timescale 1ns / 1ps

module delimiter_stream_splitter
    import dss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [PAT_W-1:0]     i_cfg_data,
    dss_src_if.sink              i_src,
    dss_piece_if.source          o_piece
);

    logic push;
    logic q_full;
    logic head_valid;
    logic pop;
    t_run run;
    t_run head;

    dss_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_src      (i_src),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_run      (run)
    );

    dss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_run        (run),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    dss_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_piece      (o_piece)
    );

endmodule

[design/dss_checker.sv]
// port-level checks on the piece output of the splitter
`timescale 1ns / 1ps

module dss_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_piece_byte,
    input logic       i_byte_valid,
    input logic       i_piece_end,
    input logic       i_run_last
);

    // a stalled beat keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_piece_byte, i_byte_valid,
                                                     i_piece_end, i_run_last}))
        else $error("stalled piece beat changed");

    // a bare end mark always closes a piece and carries a zero byte
    a_bare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_byte_valid |-> i_piece_end && (i_piece_byte == 8'd0))
        else $error("bare end mark malformed");

    // a data byte only closes a piece at the final flush, which ends the run
    a_flush_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_byte_valid && i_piece_end |-> i_run_last)
        else $error("data byte closed a piece mid-run");

    // nothing leaves the block right after reset
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_valid)
        else $error("output valid right after reset");

endmodule

bind delimiter_stream_splitter dss_checker u_dss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_piece.valid),
    .i_ready      (o_piece.ready),
    .i_piece_byte (o_piece.piece_byte),
    .i_byte_valid (o_piece.byte_valid),
    .i_piece_end  (o_piece.piece_end),
    .i_run_last   (o_piece.run_last)
);

[tb/tb_delimiter_stream_splitter.sv]
// self-checking testbench of the delimiter stream splitter with a bytewise piece predictor
`timescale 1ns / 1ps

module tb_delimiter_stream_splitter;
    import dss_pkg::*;

    typedef logic [BYTE_W-1:0] t_octet;

    typedef struct {
        t_octet data;
        logic   lst;
    } t_src_beat;

    typedef struct {
        t_octet pbyte;
        logic   is_data;
        logic   ends_piece;
        logic   run_end;
    } t_piece;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SLOW, RX_TICK} t_rx_mode;

    localparam int RANDOM_ITEMS = 360;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_SHOWN    = 10;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = CFG_IDX_LENGTH;
    logic [PAT_W-1:0]     i_cfg_data = '0;

    dss_src_if   src_ch ();
    dss_piece_if piece_ch ();

    delimiter_stream_splitter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_src      (src_ch),
        .o_piece    (piece_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        src_ch.valid       = 1'b0;
        src_ch.source_byte = '0;
        src_ch.source_last = 1'b0;
        piece_ch.ready     = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("tb_delimiter_stream_splitter: done, errors");
        $finish;
    end

    // splitter state as the testbench sees it
    logic [LEN_W-1:0] cfg_len = LEN_RESET;
    logic [PAT_W-1:0] cfg_pat = PAT_RESET;
    t_octet           held [PEND_DEPTH];
    int               held_cnt  = 0;
    bit               piece_live = 1'b0;

    t_src_beat src_q [$];
    t_piece    pieces_due [$];
    int        err_count = 0;

    function automatic int eff_len();
        if (cfg_len == 0)
            return 1;
        if (cfg_len > MAX_DELIM_BYTES)
            return MAX_DELIM_BYTES;
        return int'(cfg_len);
    endfunction

    function automatic t_piece mk_piece(t_octet b, logic is_data, logic ends_piece);
        t_piece p;
        p.pbyte      = b;
        p.is_data    = is_data;
        p.ends_piece = ends_piece;
        p.run_end    = 1'b0;
        return p;
    endfunction

    // scan held bytes plus the new byte, queue the pieces they produce
    task automatic split_beat(input t_octet b, input logic lst);
        t_octet win [SLOTS];
        t_piece run [$];
        int     len;
        int     h;
        int     w;
        int     i;
        bit     ok;
        len = eff_len();
        for (i = 0; i < held_cnt; i++)
            win[i] = held[i];
        win[held_cnt] = b;
        w = held_cnt + 1;
        h = 0;
        while (w > 0) begin
            ok = 1'b1;
            if (w >= len) begin
                for (i = 0; i < len; i++)
                    if (win[h + i] != cfg_pat[8*i +: 8])
                        ok = 1'b0;
                if (ok) begin
                    run.insert(run.size(), mk_piece('0, 1'b0, 1'b1));
                    piece_live = 1'b0;
                    h += len;
                    w -= len;
                    continue;
                end
            end else begin
                // a prefix of the delimiter stays held
                for (i = 0; i < w; i++)
                    if (win[h + i] != cfg_pat[8*i +: 8])
                        ok = 1'b0;
                if (ok)
                    break;
            end
            run.insert(run.size(), mk_piece(win[h], 1'b1, 1'b0));
            piece_live = 1'b1;
            h++;
            w--;
        end
        if (lst) begin
            while (w > 0) begin
                run.insert(run.size(), mk_piece(win[h], 1'b1, 1'b0));
                piece_live = 1'b1;
                h++;
                w--;
            end
            if (piece_live) begin
                if (run.size() > 0 && run[run.size()-1].is_data)
                    run[run.size()-1].ends_piece = 1'b1;
                else
                    run.insert(run.size(), mk_piece('0, 1'b0, 1'b1));
            end
            piece_live = 1'b0;
            held_cnt   = 0;
        end else begin
            for (i = 0; i < w; i++)
                held[i] = win[h + i];
            held_cnt = w;
        end
        if (run.size() > 0)
            run[run.size()-1].run_end = 1'b1;
        foreach (run[j])
            pieces_due.insert(pieces_due.size(), run[j]);
    endtask

    // sampling at the rising edge: piece beats first, then the source beat
    bit     src_acc = 1'b0;
    t_piece exp_p;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (piece_ch.valid && piece_ch.ready) begin
                if (pieces_due.size() == 0) begin
                    if (err_count < MAX_SHOWN)
                        $display("unexpected piece beat: byte=%02h data=%0b end=%0b last=%0b",
                                 piece_ch.piece_byte, piece_ch.byte_valid,
                                 piece_ch.piece_end, piece_ch.run_last);
                    err_count++;
                end else begin
                    exp_p = pieces_due.pop_front();
                    if (piece_ch.piece_byte !== exp_p.pbyte ||
                        piece_ch.byte_valid !== exp_p.is_data ||
                        piece_ch.piece_end !== exp_p.ends_piece ||
                        piece_ch.run_last !== exp_p.run_end) begin
                        if (err_count < MAX_SHOWN)
                            $display({"piece beat mismatch: expected byte=%02h data=%0b end=%0b",
                                      " last=%0b, got byte=%02h data=%0b end=%0b last=%0b"},
                                     exp_p.pbyte, exp_p.is_data, exp_p.ends_piece,
                                     exp_p.run_end, piece_ch.piece_byte, piece_ch.byte_valid,
                                     piece_ch.piece_end, piece_ch.run_last);
                        err_count++;
                    end
                end
            end
            if (src_ch.valid && src_ch.ready)
                split_beat(src_ch.source_byte, src_ch.source_last);
        end
        src_acc <= i_rst_n && src_ch.valid && src_ch.ready;
    end

    // source driver: bursts of random length with random gaps
    int        burst_left = 0;
    int        gap_left   = 0;
    t_src_beat nxt;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            src_ch.valid <= 1'b0;
        end else if (!src_ch.valid || src_acc) begin
            if (gap_left != 0) begin
                src_ch.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (src_q.size() == 0) begin
                src_ch.valid <= 1'b0;
            end else begin
                nxt = src_q.pop_front();
                src_ch.valid       <= 1'b1;
                src_ch.source_byte <= nxt.data;
                src_ch.source_last <= nxt.lst;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    int hold_reqs    = 0;
    int holds_served = 0;
    int rx_hold_left = 0;

    always @(negedge i_clk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end else if (holds_served != hold_reqs) begin
            rx_hold_left <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end
    end

    // receiver stall pattern
    t_rx_mode rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    int       rx_tick      = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            piece_ch.ready <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 1;
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(8, 80);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            if (rx_hold_left != 0) begin
                piece_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN: piece_ch.ready <= 1'b1;
                    RX_COIN: piece_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SLOW: piece_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: piece_ch.ready <= ((rx_tick % 5) != 4);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_IDX_LENGTH:  cfg_len = data[LEN_W-1:0];
            CFG_IDX_PATTERN: cfg_pat = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // items go into the queue at the rising edge, the driver takes them at the falling one
    task automatic queue_bytes(input t_octet str [$], input bit term);
        t_src_beat sb;
        @(posedge i_clk);
        foreach (str[i]) begin
            sb.data = str[i];
            sb.lst  = term && (i == str.size() - 1);
            src_q.insert(src_q.size(), sb);
        end
    endtask

    // all beats taken, all pieces seen, then an idle wait for runs with no result
    task automatic settle();
        @(posedge i_clk);
        while (src_q.size() != 0 || src_ch.valid)
            @(posedge i_clk);
        @(negedge i_clk);
        while (pieces_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return '0;
            1:       return LEN_W'($urandom_range(9, 15));
            2:       return LEN_W'(MAX_DELIM_BYTES);
            3:       return LEN_W'(1);
            default: return LEN_W'($urandom_range(1, MAX_DELIM_BYTES));
        endcase
    endfunction

    function automatic logic [PAT_W-1:0] pick_pattern();
        logic [PAT_W-1:0] p;
        t_octet           b;
        int               r;
        int               i;
        r = $urandom_range(0, 5);
        b = t_octet'($urandom_range(0, 255));
        p = {$urandom, $urandom};
        case (r)
            // one byte repeated: overlapping delimiter matches
            1: p = {8{b}};
            2: for (i = 0; i < MAX_DELIM_BYTES; i++)
                   p[8*i +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
            3: p = '1;
            4: p = '0;
            default: ;
        endcase
        return p;
    endfunction

    int rand_items = 0;

    // string built from delimiters, delimiter prefixes and stray bytes
    task automatic add_string(input int n, input bit term);
        t_octet str [$];
        int     len;
        int     r;
        int     k;
        int     p;
        len = eff_len();
        while (str.size() < n) begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
                for (k = 0; k < len; k++)
                    str.insert(str.size(), cfg_pat[8*k +: 8]);
            end else if (r < 40) begin
                p = $urandom_range(0, len - 1);
                for (k = 0; k < p; k++)
                    str.insert(str.size(), cfg_pat[8*k +: 8]);
            end else if (r < 55) begin
                str.insert(str.size(), t_octet'($urandom_range(0, 255)));
            end else begin
                k = $urandom_range(0, len - 1);
                str.insert(str.size(), cfg_pat[8*k +: 8]);
            end
        end
        queue_bytes(str, term);
        rand_items += str.size();
    endtask

    int phase = 0;
    int nstr;
    int s;

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset delimiter ',': extreme bytes, empty pieces, source ending in a delimiter
        queue_bytes({8'h00, 8'hFF, 8'h2C, 8'h2C, 8'h62}, 1'b1);
        queue_bytes({8'h2C}, 1'b1);
        queue_bytes({8'h7A}, 1'b1);
        settle();

        // "aa": non-overlapping matches, held bytes flushed on the last byte
        write_reg(CFG_IDX_LENGTH, 64'd2);
        write_reg(CFG_IDX_PATTERN, 64'h6161);
        queue_bytes({8'h61, 8'h61, 8'h61}, 1'b1);
        queue_bytes({8'h78, 8'h61}, 1'b1);
        queue_bytes({8'h61}, 1'b0);
        settle();

        // length shrinks while a byte is held
        write_reg(CFG_IDX_LENGTH, 64'd1);
        queue_bytes({8'h62}, 1'b1);
        settle();

        // length zero acts as one
        write_reg(CFG_IDX_LENGTH, 64'd0);
        write_reg(CFG_IDX_PATTERN, 64'd0);
        queue_bytes({8'h00, 8'h07}, 1'b1);
        settle();

        // length saturates at eight, a flush of eight data beats
        write_reg(CFG_IDX_LENGTH, 64'd15);
        write_reg(CFG_IDX_PATTERN, '1);
        queue_bytes({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01}, 1'b1);
        settle();

        while (rand_items < RANDOM_ITEMS) begin
            phase++;
            if (phase == 1 || $urandom_range(0, 2) != 0) begin
                write_reg(CFG_IDX_LENGTH, PAT_W'(pick_len()));
                write_reg(CFG_IDX_PATTERN, pick_pattern());
            end
            if (phase == 2 || phase == 7)
                hold_reqs <= hold_reqs + 1;
            nstr = (phase == 2) ? 6 : $urandom_range(1, 4);
            // the last string of a phase may stay open across the next register write
            for (s = 0; s < nstr; s++)
                add_string($urandom_range(1, 16), (s < nstr - 1) || ($urandom_range(0, 3) != 0));
            settle();
        end

        settle();
        if (err_count == 0)
            $display("tb_delimiter_stream_splitter: done, clean");
        else
            $display("tb_delimiter_stream_splitter: done, errors");
        $finish;
    end

endmodule
